>>> design/tse_pkg.sv
// Shared types and codes for the tournament selection engine.
// Used by the top level; has no dependencies of its own.
package tse_pkg;

    // Command codes carried in s_axis_tuser
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_DRAW  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_POP_COUNT = 2'd0;
    localparam logic [1:0] CFG_TOUR_SIZE = 2'd1;
    localparam logic [1:0] CFG_QUOTA     = 2'd2;

    // Report kinds carried in m_axis_tuser
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_OUTCOME = 1'b1;

    localparam int IDX_W = 10;

    typedef logic [9:0]  t_idx;
    typedef logic [10:0] t_total;
    typedef logic [15:0] t_cnt;
    typedef logic [31:0] t_fit;

    localparam t_total SEL_MAX = 11'h7FF;
    localparam t_cnt   CNT_MAX = 16'hFFFF;

    // Input word, lowest bits last
    typedef struct packed {
        logic [5:0] pad;
        t_fit       fitness_value;
        t_idx       entry_index;
    } t_in_word;

    // Result word, lowest bits last
    typedef struct packed {
        logic [3:0] pad;
        logic       quota_error;
        logic       selection_done;
        t_cnt       repeat_wins;
        t_cnt       tournaments_run;
        t_total     target_total;
        t_total     selected_total;
        logic       no_winner;
        logic       newly_selected;
        t_idx       winner_index;
    } t_out_word;

endpackage

>>> design/tse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/tournament_selection_engine.sv
// Tournament selection engine: lowest-fitness tournaments over a stored population.
// A load word passes through the index wrap register, then the fitness memory write.
// A candidate word is evaluated against the registered read of the fitness and status
// memories; the last draw of a tournament also waits for the output register to be
// free. A start word gives its report once the output register is free, followed by a
// status clearing pass over MAX_ENTRIES entries that accepts no word; the same pass
// runs after reset. Other words (ignored candidates, unused command) are dropped.
// Depends on tse_pkg and tse_ram.
module tournament_selection_engine #(
    parameter int MAX_ENTRIES    = 1024,
    parameter int FITNESS_BITS   = 32,
    parameter int MAX_TOURNAMENT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // entry_index[9:0], fitness_value[41:10]
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // winner_index[9:0], newly_selected[10], no_winner[11], selected_total[22:12],
    // target_total[33:23], tournaments_run[49:34], repeat_wins[65:50],
    // selection_done[66], quota_error[67]
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tuser   // report_kind[0]
);

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int TGW  = CW + 1;
    localparam int PW   = CW + 16;
    localparam int TW0  = $clog2(MAX_TOURNAMENT + 1);
    localparam int TCW  = (TW0 > 5) ? TW0 : 5;
    localparam int TIW  = (MAX_TOURNAMENT > 1) ? $clog2(MAX_TOURNAMENT) : 1;
    localparam int SH   = tse_pkg::IDX_W + AW;
    localparam int RW   = SH + 1;
    localparam int QPW  = tse_pkg::IDX_W + RW;
    localparam int RMW  = tse_pkg::IDX_W + CW;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << SH) + 64'(MAX_ENTRIES) - 64'd1) / 64'(MAX_ENTRIES));
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ENTRIES - 1);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_LOAD   = 5'b00100,
        S_DRAW   = 5'b01000,
        S_REPORT = 5'b10000
    } t_state;

    tse_pkg::t_in_word in_word;
    assign in_word = s_axis_tdata;

    // configuration
    logic [10:0] r_pop;
    logic [4:0]  r_tsize;
    logic [15:0] r_quota;

    t_state r_state;

    logic [AW-1:0]           r_addr;
    logic                    r_in_range;
    tse_pkg::t_idx           r_ld_idx;
    tse_pkg::t_idx           r_ld_q;
    logic [FITNESS_BITS-1:0] r_ld_fit;
    logic [AW-1:0]           r_clr_addr;
    logic [PW-1:0]           r_prod;

    logic [AW-1:0]           r_touched [MAX_TOURNAMENT];
    logic [TCW-1:0]          r_fill;
    logic [TCW-1:0]          r_draw;
    logic                    r_have_best;
    logic [AW-1:0]           r_best_idx;
    logic [FITNESS_BITS-1:0] r_best_fit;
    logic                    r_best_sel;

    tse_pkg::t_total r_sel_cnt;
    logic [TGW-1:0]  r_target;
    tse_pkg::t_cnt   r_tour_cnt;
    tse_pkg::t_cnt   r_rep_cnt;
    logic            r_active;

    logic               r_out_valid;
    logic               r_out_kind;
    tse_pkg::t_out_word r_out_word;

    // memory ports
    logic [AW-1:0]           ram_raddr;
    logic [FITNESS_BITS-1:0] fit_rd;
    logic                    sel_rd;
    logic                    fit_we;
    logic [AW-1:0]           fit_waddr;
    logic                    sel_we;
    logic [AW-1:0]           sel_waddr;
    logic                    sel_wdata;

    // derived values
    logic [CW-1:0]  eff_count;
    logic [TCW-1:0] eff_tsize;
    logic           accept;
    logic [QPW-1:0] ld_prod;
    logic [RMW-1:0] ld_rem;
    logic           dup;
    logic           take;
    logic           upd;
    logic           nb_have;
    logic [AW-1:0]  nb_idx;
    logic [FITNESS_BITS-1:0] nb_fit;
    logic           nb_sel;
    logic [TCW-1:0] draw_nxt;
    logic           last_draw;
    logic           out_free;
    logic           out_load;
    logic           fresh;
    logic           fin;
    tse_pkg::t_total n_sel_cnt;
    tse_pkg::t_cnt   n_tour_cnt;
    tse_pkg::t_cnt   n_rep_cnt;
    logic [PW:0]     tgt_sum;
    logic [TGW-1:0]  tgt_raw;
    logic [TGW-1:0]  tgt_even;
    logic            tgt_err;
    tse_pkg::t_out_word outcome_word;
    tse_pkg::t_out_word report_word;

    always_comb begin
        if (r_pop == 11'd0) begin
            eff_count = CW'(1);
        end else if (32'(r_pop) > 32'(MAX_ENTRIES)) begin
            eff_count = CW'(MAX_ENTRIES);
        end else begin
            eff_count = CW'(r_pop);
        end
        if (r_tsize == 5'd0) begin
            eff_tsize = TCW'(1);
        end else if (TCW'(r_tsize) > TCW'(MAX_TOURNAMENT)) begin
            eff_tsize = TCW'(MAX_TOURNAMENT);
        end else begin
            eff_tsize = TCW'(r_tsize);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ram_raddr     = (r_state == S_IDLE) ? AW'(in_word.entry_index) : r_addr;

    // load index wrap: reciprocal gives the exact quotient for any 10-bit index
    assign ld_prod = QPW'(in_word.entry_index) * QPW'(RECIP);
    assign ld_rem  = RMW'(r_ld_idx) - RMW'(r_ld_q) * RMW'(MAX_ENTRIES);

    // draw evaluation against the memory read data
    always_comb begin
        dup = 1'b0;
        for (int k = 0; k < MAX_TOURNAMENT; k++) begin
            if ((TCW'(k) < r_fill) && (r_touched[k] == r_addr)) begin
                dup = 1'b1;
            end
        end
    end

    assign take      = r_in_range && !dup;
    assign upd       = take && (!r_have_best || (fit_rd < r_best_fit));
    assign nb_have   = r_have_best || take;
    assign nb_idx    = upd ? r_addr : r_best_idx;
    assign nb_fit    = upd ? fit_rd : r_best_fit;
    assign nb_sel    = upd ? sel_rd : r_best_sel;
    assign draw_nxt  = r_draw + TCW'(1);
    assign last_draw = (draw_nxt >= eff_tsize);
    assign out_free  = !r_out_valid || m_axis_tready;
    assign fin       = (r_state == S_DRAW) && last_draw && out_free;
    assign out_load  = fin || ((r_state == S_REPORT) && out_free);
    assign fresh     = nb_have && !nb_sel;

    always_comb begin
        n_sel_cnt  = r_sel_cnt;
        n_tour_cnt = r_tour_cnt;
        n_rep_cnt  = r_rep_cnt;
        if (r_tour_cnt != tse_pkg::CNT_MAX) begin
            n_tour_cnt = r_tour_cnt + 16'd1;
        end
        if (fresh && (r_sel_cnt != tse_pkg::SEL_MAX)) begin
            n_sel_cnt = r_sel_cnt + 11'd1;
        end
        if (nb_have && nb_sel && (r_rep_cnt != tse_pkg::CNT_MAX)) begin
            n_rep_cnt = r_rep_cnt + 16'd1;
        end
    end

    always_comb begin
        outcome_word                 = '0;
        outcome_word.winner_index    = nb_have ? tse_pkg::t_idx'(nb_idx) : '0;
        outcome_word.newly_selected  = fresh;
        outcome_word.no_winner       = !nb_have;
        outcome_word.selected_total  = n_sel_cnt;
        outcome_word.target_total    = tse_pkg::t_total'(r_target);
        outcome_word.tournaments_run = n_tour_cnt;
        outcome_word.repeat_wins     = n_rep_cnt;
        outcome_word.selection_done  = (32'(n_sel_cnt) >= 32'(r_target));
        outcome_word.quota_error     = 1'b0;
    end

    // target: ceil(count * quota / 2^16), then up to even
    assign tgt_sum  = (PW + 1)'(r_prod) + (PW + 1)'(16'hFFFF);
    assign tgt_raw  = tgt_sum[PW:16];
    assign tgt_even = tgt_raw + TGW'(tgt_raw[0]);
    assign tgt_err  = (tgt_even > TGW'(eff_count));

    always_comb begin
        report_word                = '0;
        report_word.target_total   = tse_pkg::t_total'(tgt_even);
        report_word.selection_done = !tgt_err && (tgt_even == '0);
        report_word.quota_error    = tgt_err;
    end

    // memory write ports
    assign fit_we    = (r_state == S_LOAD);
    assign fit_waddr = ld_rem[AW-1:0];
    assign sel_we    = (r_state == S_CLEAR) || (fin && fresh);
    assign sel_waddr = (r_state == S_CLEAR) ? r_clr_addr : nb_idx;
    assign sel_wdata = (r_state != S_CLEAR);

    tse_ram #(.WIDTH(FITNESS_BITS), .DEPTH(MAX_ENTRIES)) u_fitness_ram (
        .i_clk   (i_clk),
        .i_we    (fit_we),
        .i_waddr (fit_waddr),
        .i_wdata (r_ld_fit),
        .i_raddr (ram_raddr),
        .o_rdata (fit_rd)
    );

    tse_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (sel_we),
        .i_waddr (sel_waddr),
        .i_wdata (sel_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (sel_rd)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(eff_count) * PW'(r_quota);
        if (accept) begin
            r_addr     <= AW'(in_word.entry_index);
            r_in_range <= (32'(in_word.entry_index) < 32'(eff_count));
            r_ld_idx   <= in_word.entry_index;
            r_ld_q     <= ld_prod[SH +: tse_pkg::IDX_W];
            r_ld_fit   <= FITNESS_BITS'(in_word.fitness_value);
        end
        if ((r_state == S_DRAW) && (!last_draw || out_free)) begin
            r_best_idx <= nb_idx;
            r_best_fit <= nb_fit;
            r_best_sel <= nb_sel;
            if (take && (r_fill < TCW'(MAX_TOURNAMENT))) begin
                r_touched[r_fill[TIW-1:0]] <= r_addr;
            end
        end
        if (fin) begin
            r_out_kind <= tse_pkg::KIND_OUTCOME;
            r_out_word <= outcome_word;
        end else if ((r_state == S_REPORT) && out_free) begin
            r_out_kind <= tse_pkg::KIND_START;
            r_out_word <= report_word;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop       <= 11'd1024;
            r_tsize     <= 5'd2;
            r_quota     <= 16'd32768;
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_fill      <= '0;
            r_draw      <= '0;
            r_have_best <= 1'b0;
            r_sel_cnt   <= '0;
            r_target    <= '0;
            r_tour_cnt  <= '0;
            r_rep_cnt   <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tse_pkg::CFG_POP_COUNT: r_pop   <= i_cfg_data[10:0];
                    tse_pkg::CFG_TOUR_SIZE: r_tsize <= i_cfg_data[4:0];
                    tse_pkg::CFG_QUOTA:     r_quota <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == LAST_ADDR) begin
                        r_clr_addr <= '0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        case (s_axis_tuser)
                            tse_pkg::CMD_LOAD:  r_state <= S_LOAD;
                            tse_pkg::CMD_START: r_state <= S_REPORT;
                            tse_pkg::CMD_DRAW: begin
                                if (r_active) begin
                                    r_state <= S_DRAW;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_LOAD: begin
                    r_state <= S_IDLE;
                end
                S_DRAW: begin
                    if (!last_draw) begin
                        r_have_best <= nb_have;
                        r_draw      <= draw_nxt;
                        if (take && (r_fill < TCW'(MAX_TOURNAMENT))) begin
                            r_fill <= r_fill + TCW'(1);
                        end
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        // close the tournament: marks revert by dropping the list
                        r_have_best <= 1'b0;
                        r_draw      <= '0;
                        r_fill      <= '0;
                        r_sel_cnt   <= n_sel_cnt;
                        r_tour_cnt  <= n_tour_cnt;
                        r_rep_cnt   <= n_rep_cnt;
                        r_active    <= !(32'(n_sel_cnt) >= 32'(r_target));
                        r_state     <= S_IDLE;
                    end
                end
                S_REPORT: begin
                    if (out_free) begin
                        r_have_best <= 1'b0;
                        r_draw      <= '0;
                        r_fill      <= '0;
                        r_sel_cnt   <= '0;
                        r_tour_cnt  <= '0;
                        r_rep_cnt   <= '0;
                        r_target    <= tgt_even;
                        r_active    <= !tgt_err && (tgt_even != '0);
                        r_clr_addr  <= '0;
                        r_state     <= S_CLEAR;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;
    assign m_axis_tuser  = r_out_kind;

endmodule

>>> tb/tournament_selection_engine_tb.sv
// Self-checking testbench for the tournament selection engine: drives the word stream and
// the register port, predicts reports with a behavioural model of the selection; pinned
// rows type in their start report. Depends on tse_pkg and the engine RTL.
module tournament_selection_engine_tb;
    import tse_pkg::*;

    localparam int POP_MAX     = 1024;
    localparam int TOUR_MAX    = 16;
    localparam int WORD_TARGET = 950;
    localparam int QUIET_FROM  = 850;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_ROWS    = 29;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] CFG_NONE   = 2'd3;

    typedef struct packed {
        logic      kind;
        t_out_word w;
    } t_report;

    typedef enum logic [1:0] {ROW_REG, ROW_WORD, ROW_PINNED} t_row_kind;

    // code is a register index for ROW_REG, a command otherwise; tgt/done/err are
    // the start report typed in for ROW_PINNED rows
    typedef struct packed {
        t_row_kind  kind;
        logic [1:0] code;
        logic [15:0] val;
        t_idx       idx;
        t_fit       fit;
        t_total     tgt;
        logic       done;
        logic       err;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // entry_index[9:0], fitness_value[41:10]
    logic [1:0]  s_axis_tuser = '0;   // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // winner_index, newly_selected, no_winner, selected_total, target_total,
    // tournaments_run, repeat_wins, selection_done, quota_error
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;        // report_kind[0]

    tournament_selection_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // Selection model state
    logic [10:0] cfg_pop;
    logic [4:0]  cfg_tour;
    logic [15:0] cfg_quota;
    t_fit        fit_mem [POP_MAX];
    bit          loaded [POP_MAX];
    bit          sel_mark [POP_MAX];
    bit          tour_mark [POP_MAX];
    t_idx        touched [$];
    int unsigned draws_in_tour;
    t_idx        best_idx;
    t_fit        best_fit;
    bit          have_best;
    t_total      sel_total;
    t_total      tgt_total;
    t_cnt        tours_run;
    t_cnt        repeat_wins;
    bit          sel_active;

    t_report     due_reports [$];
    int          fail_count = 0;
    int          words_sent = 0;
    int          phases_run = 0;
    int          reports_checked = 0;
    int          outcomes_seen = 0;
    int          no_winner_seen = 0;
    int          quota_err_seen = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    bit          quiet = 1'b0;
    logic [1:0]  last_cmd = CMD_LOAD;

    t_row dir_rows [DIR_ROWS] = '{
        // start straight after reset: 1024 entries at half quota
        '{ROW_PINNED, CMD_START,     16'd0,     10'd0,    32'd0,        11'd512, 1'b0, 1'b0},
        '{ROW_REG,    CFG_POP_COUNT, 16'd4,     10'd0,    32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_REG,    CFG_TOUR_SIZE, 16'd2,     10'd0,    32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_REG,    CFG_QUOTA,     16'hFFFF,  10'd0,    32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_WORD,   CMD_LOAD,      16'd0,     10'd0,    32'd100,      11'd0,   1'b0, 1'b0},
        '{ROW_WORD,   CMD_LOAD,      16'd0,     10'd1,    32'hFFFFFFFF, 11'd0,   1'b0, 1'b0},
        '{ROW_WORD,   CMD_LOAD,      16'd0,     10'd2,    32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_WORD,   CMD_LOAD,      16'd0,     10'd3,    32'd100,      11'd0,   1'b0, 1'b0},
        '{ROW_WORD,   CMD_LOAD,      16'd0,     10'd1023, 32'hA5A55A5A, 11'd0,   1'b0, 1'b0},
        '{ROW_PINNED, CMD_START,     16'd0,     10'd0,    32'd0,        11'd4,   1'b0, 1'b0},
        // tie on fitness: the earlier draw keeps the win
        '{ROW_WORD,   CMD_DRAW,      16'd0,     10'd3,    32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_WORD,   CMD_DRAW,      16'd0,     10'd0,    32'd0,        11'd0,   1'b0, 1'b0},
        // same entry twice in one tournament
        '{ROW_WORD,   CMD_DRAW,      16'd0,     10'd1,    32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_WORD,   CMD_DRAW,      16'd0,     10'd1,    32'd0,        11'd0,   1'b0, 1'b0},
        // both draws beyond the population: no winner
        '{ROW_WORD,   CMD_DRAW,      16'd0,     10'd5,    32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_WORD,   CMD_DRAW,      16'd0,     10'd1023, 32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_WORD,   CMD_DRAW,      16'd0,     10'd2,    32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_WORD,   CMD_DRAW,      16'd0,     10'd3,    32'd0,        11'd0,   1'b0, 1'b0},
        // already selected entry wins again
        '{ROW_WORD,   CMD_DRAW,      16'd0,     10'd3,    32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_WORD,   CMD_DRAW,      16'd0,     10'd0,    32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_WORD,   CMD_DRAW,      16'd0,     10'd0,    32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_WORD,   CMD_DRAW,      16'd0,     10'd1,    32'd0,        11'd0,   1'b0, 1'b0},
        // target reached: further draws and the unused command are dropped
        '{ROW_WORD,   CMD_DRAW,      16'd0,     10'd2,    32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_WORD,   CMD_UNUSED,    16'd0,     10'd1023, 32'hFFFFFFFF, 11'd0,   1'b0, 1'b0},
        // odd population at full quota overshoots the count
        '{ROW_REG,    CFG_POP_COUNT, 16'd3,     10'd0,    32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_PINNED, CMD_START,     16'd0,     10'd0,    32'd0,        11'd4,   1'b0, 1'b1},
        '{ROW_WORD,   CMD_DRAW,      16'd0,     10'd0,    32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_REG,    CFG_QUOTA,     16'd0,     10'd0,    32'd0,        11'd0,   1'b0, 1'b0},
        '{ROW_PINNED, CMD_START,     16'd0,     10'd0,    32'd0,        11'd0,   1'b1, 1'b0}
    };

    function automatic int unsigned live_count();
        if (cfg_pop == 0) return 1;
        if (cfg_pop > POP_MAX) return POP_MAX;
        return cfg_pop;
    endfunction

    function automatic int unsigned draws_per_tour();
        if (cfg_tour == 0) return 1;
        if (cfg_tour > TOUR_MAX) return TOUR_MAX;
        return cfg_tour;
    endfunction

    function automatic void end_tournament();
        touched.delete();
        draws_in_tour = 0;
        have_best = 1'b0;
        best_idx = '0;
        best_fit = '0;
    endfunction

    function automatic void reset_selection_model();
        cfg_pop = 11'd1024;
        cfg_tour = 5'd2;
        cfg_quota = 16'd32768;
        foreach (sel_mark[i]) begin
            sel_mark[i] = 1'b0;
            tour_mark[i] = 1'b0;
            loaded[i] = 1'b0;
        end
        end_tournament();
        sel_total = '0;
        tgt_total = '0;
        tours_run = '0;
        repeat_wins = '0;
        sel_active = 1'b0;
    endfunction

    function automatic t_report status_report(input logic kind, input t_idx win,
                                              input logic fresh, input logic none,
                                              input logic err);
        t_report r;
        r = '0;
        r.kind = kind;
        r.w.winner_index = win;
        r.w.newly_selected = fresh;
        r.w.no_winner = none;
        r.w.selected_total = sel_total;
        r.w.target_total = tgt_total;
        r.w.tournaments_run = tours_run;
        r.w.repeat_wins = repeat_wins;
        r.w.selection_done = (sel_total >= tgt_total) && !err;
        r.w.quota_error = err;
        return r;
    endfunction

    // Advance the selection by one accepted word; returns 1 when it yields a report
    function automatic bit advance_selection(input logic [1:0] cmd, input t_idx idx,
                                             input t_fit fit, output t_report rep);
        int unsigned span;
        int unsigned target;
        logic fresh;
        logic none;
        t_idx win;
        rep = '0;
        case (cmd)
            CMD_LOAD: begin
                fit_mem[idx] = fit;
                return 1'b0;
            end
            CMD_START: begin
                span = live_count();
                target = (span * cfg_quota + 65535) >> 16;
                if ((target & 1) != 0) target++;
                foreach (sel_mark[i]) begin
                    sel_mark[i] = 1'b0;
                    tour_mark[i] = 1'b0;
                end
                end_tournament();
                sel_total = '0;
                tours_run = '0;
                repeat_wins = '0;
                tgt_total = t_total'(target);
                sel_active = (target <= span) && (target > 0);
                rep = status_report(KIND_START, '0, 1'b0, 1'b0, target > span);
                return 1'b1;
            end
            CMD_DRAW: begin
                if (!sel_active) return 1'b0;
                // out-of-range draws and repeats within the tournament still use a draw
                if (idx < live_count() && !tour_mark[idx]) begin
                    tour_mark[idx] = 1'b1;
                    touched.push_back(idx);
                    if (!have_best || fit_mem[idx] < best_fit) begin
                        have_best = 1'b1;
                        best_idx = idx;
                        best_fit = fit_mem[idx];
                    end
                end
                draws_in_tour++;
                if (draws_in_tour < draws_per_tour()) return 1'b0;
                if (tours_run != CNT_MAX) tours_run++;
                fresh = 1'b0;
                none = 1'b0;
                win = '0;
                if (have_best) begin
                    win = best_idx;
                    if (!sel_mark[win]) begin
                        sel_mark[win] = 1'b1;
                        if (sel_total != SEL_MAX) sel_total++;
                        fresh = 1'b1;
                    end else if (repeat_wins != CNT_MAX) begin
                        repeat_wins++;
                    end
                end else begin
                    none = 1'b1;
                end
                foreach (touched[k]) tour_mark[touched[k]] = 1'b0;
                end_tournament();
                if (sel_total >= tgt_total) sel_active = 1'b0;
                rep = status_report(KIND_OUTCOME, win, fresh, none, 1'b0);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Hold the stream idle until every report is in, then let the engine drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat ((last_cmd == CMD_START) ? POP_MAX + 16 : 16) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] ridx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= ridx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (ridx)
            CFG_POP_COUNT: cfg_pop = val[10:0];
            CFG_TOUR_SIZE: cfg_tour = val[4:0];
            CFG_QUOTA:     cfg_quota = val;
            default: ;
        endcase
    endtask

    task automatic push_word(input logic [1:0] cmd, input t_idx idx, input t_fit fit,
                             input bit pinned = 1'b0, input t_total pin_tgt = '0,
                             input logic pin_done = 1'b0, input logic pin_err = 1'b0);
        t_report rep;
        bit yields;
        bit counted;
        if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, fit, idx};
        s_axis_tuser <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        counted = (cmd == CMD_LOAD) || (cmd == CMD_START) || (cmd == CMD_DRAW && sel_active);
        if (cmd == CMD_LOAD) loaded[idx] = 1'b1;
        yields = advance_selection(cmd, idx, fit, rep);
        if (pinned) begin
            rep = '0;
            rep.kind = KIND_START;
            rep.w.target_total = pin_tgt;
            rep.w.selection_done = pin_done;
            rep.w.quota_error = pin_err;
        end
        if (yields || pinned) due_reports.push_back(rep);
        if (counted) words_sent++;
        last_cmd = cmd;
        quiet = (words_sent >= QUIET_FROM);
    endtask

    function automatic t_fit pick_fitness();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return t_fit'($urandom_range(0, 15));   // close values make ties
            default: return t_fit'($urandom);
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Receiver: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (stalls_on && !quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_report want;
        t_out_word got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (due_reports.size() == 0) begin
                $error("report word with nothing expected: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = due_reports.pop_front();
                check_field("report_kind", want.kind, m_axis_tuser);
                check_field("winner_index", want.w.winner_index, got.winner_index);
                check_field("newly_selected", want.w.newly_selected, got.newly_selected);
                check_field("no_winner", want.w.no_winner, got.no_winner);
                check_field("selected_total", want.w.selected_total, got.selected_total);
                check_field("target_total", want.w.target_total, got.target_total);
                check_field("tournaments_run", want.w.tournaments_run, got.tournaments_run);
                check_field("repeat_wins", want.w.repeat_wins, got.repeat_wins);
                check_field("selection_done", want.w.selection_done, got.selection_done);
                check_field("quota_error", want.w.quota_error, got.quota_error);
                reports_checked++;
                if (want.kind == KIND_OUTCOME) outcomes_seen++;
                if (want.w.no_winner) no_winner_seen++;
                if (want.w.quota_error) quota_err_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, due_reports.size());
            $display("tournament_selection_engine test failed");
            $finish;
        end
    end

    initial begin
        bit          reg_open;
        int unsigned span;
        int unsigned budget;
        int unsigned pick;
        logic [10:0] pop_val;
        logic [4:0]  tour_val;
        logic [15:0] quota_val;
        t_idx        idx;
        t_idx        pool [$];

        reset_selection_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        reg_open = 1'b0;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_REG) begin
                if (!reg_open) settle();
                write_reg(dir_rows[r].code, dir_rows[r].val);
                reg_open = 1'b1;
            end else begin
                if (reg_open) begin
                    i_cfg_we <= 1'b0;
                    reg_open = 1'b0;
                end
                push_word(dir_rows[r].code, dir_rows[r].idx, dir_rows[r].fit,
                          dir_rows[r].kind == ROW_PINNED, dir_rows[r].tgt,
                          dir_rows[r].done, dir_rows[r].err);
            end
        end

        while (words_sent < WORD_TARGET) begin
            settle();
            phases_run++;
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);

            case ($urandom_range(0, 19))
                0: pop_val = 11'd0;
                1: pop_val = 11'd1;
                2: pop_val = 11'd1024;
                3: pop_val = 11'd2047;
                default: pop_val = 11'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 9))
                0: tour_val = 5'd0;
                1: tour_val = 5'd31;
                2: tour_val = 5'd16;
                default: tour_val = 5'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0: quota_val = 16'd0;
                1: quota_val = 16'd1;
                2: quota_val = 16'hFFFF;
                default: quota_val = 16'($urandom_range(1, 65535));
            endcase
            // junk in the bits above each register's width must be dropped
            write_reg(CFG_POP_COUNT, {5'($urandom), pop_val});
            write_reg(CFG_TOUR_SIZE, {11'($urandom), tour_val});
            if ($urandom_range(0, 3) == 0) write_reg(CFG_NONE, 16'($urandom));
            write_reg(CFG_QUOTA, quota_val);
            i_cfg_we <= 1'b0;

            span = live_count();
            if (span <= 64) begin
                for (int i = 0; i < span; i++)
                    if (!loaded[i] || $urandom_range(0, 2) == 0)
                        push_word(CMD_LOAD, t_idx'(i), pick_fitness());
            end else begin
                repeat (24) push_word(CMD_LOAD, t_idx'($urandom_range(0, span - 1)),
                                      pick_fitness());
            end
            pool.delete();
            for (int i = 0; i < span; i++)
                if (loaded[i]) pool.push_back(t_idx'(i));

            push_word(CMD_START, t_idx'($urandom), t_fit'($urandom));

            budget = $urandom_range(20, 90);
            while (budget > 0 && sel_active && words_sent < WORD_TARGET) begin
                budget--;
                pick = $urandom_range(0, 99);
                if (pick < 82) begin
                    push_word(CMD_DRAW, pool[$urandom_range(0, pool.size() - 1)],
                              t_fit'($urandom));
                end else if (pick < 90) begin
                    if (span < POP_MAX)
                        idx = t_idx'($urandom_range(span, POP_MAX - 1));
                    else
                        idx = pool[$urandom_range(0, pool.size() - 1)];
                    push_word(CMD_DRAW, idx, t_fit'($urandom));
                end else if (pick < 95) begin
                    // reload mid-selection; it counts for later draws
                    idx = t_idx'($urandom);
                    if (idx < span && !loaded[idx]) pool.push_back(idx);
                    push_word(CMD_LOAD, idx, pick_fitness());
                end else if (pick < 97) begin
                    push_word(CMD_UNUSED, t_idx'($urandom), t_fit'($urandom));
                end else if (pick < 99) begin
                    settle();
                end else begin
                    push_word(CMD_START, t_idx'($urandom), t_fit'($urandom));
                end
            end
            // a draw while the selection is inactive must be dropped
            if (!sel_active && $urandom_range(0, 1) == 0)
                push_word(CMD_DRAW, pool[0], t_fit'($urandom));
        end

        settle();
        $display("%0d words over %0d random phases, %0d reports checked",
                 words_sent, phases_run, reports_checked);
        $display("%0d tournament outcomes, %0d without a winner, %0d quota errors",
                 outcomes_seen, no_winner_seen, quota_err_seen);
        if (fail_count == 0)
            $display("tournament_selection_engine test passed");
        else
            $display("tournament_selection_engine test failed");
        $finish;
    end

endmodule
